// File: rtl/fsd_pkg.sv
// Shared types and constants of the error-diffusion dither.
// No dependencies; the front, queue, back, top level and both testbench files import it.
`default_nettype none
package fsd_pkg;
    localparam int MAX_WIDTH = 4096;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int WID_W     = 13;
    localparam int HGT_W     = 15;
    localparam int CFG_W     = 15;
    localparam int IDX_W     = 2;
    localparam int NCH       = 3;
    localparam int IN_W      = 12;
    localparam int OUT_W     = 8;
    localparam int ERR_W     = 11;
    localparam int ENT_W     = NCH * ERR_W;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_DITHER = 2'd2;

    localparam logic [WID_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RST = 15'd480;

    typedef logic [NCH-1:0][IN_W-1:0]  pix_t;
    typedef logic [NCH-1:0][ERR_W-1:0] ent_t;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
        logic             dither;
    } cfg_t;

    typedef struct packed {
        pix_t              pix;
        logic [ADDR_W-1:0] col;
        logic              has_left;
        logic              last_col;
        logic              interior;
        logic              frame_end;
    } item_t;
endpackage
`default_nettype wire

// File: rtl/fsd_pix_if.sv
// Input pixel channel: valid/ready plus three 8.4 fixed-point levels.
// Depends on nothing.
`default_nettype none
interface fsd_pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] red_in;
    logic [11:0] green_in;
    logic [11:0] blue_in;
    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface
`default_nettype wire

// File: rtl/fsd_res_if.sv
// Result channel: valid/ready plus dithered 8-bit levels and frame end.
// Depends on nothing.
`default_nettype none
interface fsd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface
`default_nettype wire

// File: rtl/fsd_front.sv
// Front end: accepts pixels, tracks raster position, classifies edge pixels.
// Depends on fsd_pkg and fsd_pix_if.
`default_nettype none
module fsd_front
    import fsd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fsd_pix_if.sink    pix,
    input  wire cfg_t  cfg,
    input  wire logic  clear_done,
    input  wire logic  push_ready,
    output logic       push_valid,
    output item_t      push_item
);
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [HGT_W-1:0]  row_reg, row_next;
    logic [WID_W-1:0]  w_eff, x_w;
    logic [HGT_W-1:0]  h_eff;
    logic              last_col, last_row, take;

    always_comb
    begin
        if (cfg.width == '0)
            w_eff = WID_W'(1);
        else if (cfg.width > WID_W'(MAX_WIDTH))
            w_eff = WID_W'(MAX_WIDTH);
        else
            w_eff = cfg.width;
        h_eff = (cfg.height == '0) ? HGT_W'(1) : cfg.height;
        x_w = ({1'b0, col_reg} >= w_eff) ? w_eff - WID_W'(1) : {1'b0, col_reg};
        last_col = (x_w == w_eff - WID_W'(1));
        last_row = ({1'b0, row_reg} + (HGT_W+1)'(1) >= {1'b0, h_eff});
    end

    assign pix.ready  = push_ready && clear_done;
    assign take       = pix.valid && pix.ready;
    assign push_valid = take;

    always_comb
    begin
        push_item.pix       = {pix.blue_in, pix.green_in, pix.red_in};
        push_item.col       = x_w[ADDR_W-1:0];
        push_item.has_left  = (x_w != '0);
        push_item.last_col  = last_col;
        push_item.interior  = cfg.dither && (x_w != '0) && !last_col && !last_row;
        push_item.frame_end = last_col && last_row;
        col_next = col_reg;
        row_next = row_reg;
        if (take)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + HGT_W'(1);
            end
            else
            begin
                col_next = x_w[ADDR_W-1:0] + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/fsd_queue.sv
// Two-entry FIFO between front and back end.
// Depends on fsd_pkg.
`default_nettype none
module fsd_queue
    import fsd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    input  wire item_t push_item,
    output logic       push_ready,
    input  wire logic  pop,
    output logic       head_valid,
    output item_t      head_item
);
    item_t      slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule
`default_nettype wire

// File: rtl/fsd_back.sv
// Back end: line error store, rounding, error shares and the result register.
// Depends on fsd_pkg and fsd_res_if.
`default_nettype none
module fsd_back
    import fsd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  head_valid,
    input  wire item_t head_item,
    output logic       pop,
    output logic       clear_done,
    fsd_res_if.source  res
);
    localparam int V_W = 19;
    localparam int R_W = 11;
    localparam int E_W = 9;

    logic [ENT_W-1:0]  line_mem [MAX_WIDTH];
    logic [ENT_W-1:0]  rd_q_reg;
    logic [ADDR_W:0]   clr_cnt_reg;

    logic              r_valid_reg;
    item_t             r_item_reg;
    logic              fwd_hit_reg, fwd_hit_next;
    ent_t              fwd_data_reg, fwd_data_next;
    ent_t              rc_reg, rc_next, lp0_reg, lp0_next, lp1_reg, lp1_next;
    logic              def_valid_reg, def_valid_next;
    logic [ADDR_W-1:0] def_addr_reg, def_addr_next;
    ent_t              def_data_reg, def_data_next;

    logic              out_valid_reg;
    logic [NCH-1:0][OUT_W-1:0] out_lvl_reg, out_lvl_next;
    logic              out_end_reg;

    logic              adv, fire_r, rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    ent_t              wr_data, a_data, b_data, nre;

    function automatic logic [ERR_W-1:0] share(input logic signed [E_W-1:0] e,
                                               input logic signed [4:0] k);
        logic signed [13:0] p;
        p = 14'(e) * 14'(k);
        share = ERR_W'(p >>> 4);
    endfunction

    assign clear_done = clr_cnt_reg[ADDR_W];
    assign adv    = !out_valid_reg || res.ready;
    assign fire_r = r_valid_reg && adv;
    assign rd_en  = adv && head_valid && clear_done;
    assign pop    = rd_en;
    assign nre    = fwd_hit_reg ? fwd_data_reg : ent_t'(rd_q_reg);

    // per-channel arithmetic
    always_comb
    begin
        logic signed [V_W-1:0]   v, e_full;
        logic [V_W-1:0]          mag, rm;
        logic signed [R_W-1:0]   r;
        logic signed [E_W-1:0]   e;
        logic                    neg;
        for (int c = 0; c < NCH; c++)
        begin
            v = $signed({3'b000, r_item_reg.pix[c], 4'b0000})
                + V_W'($signed(nre[c])) + V_W'($signed(rc_reg[c]));
            neg = v[V_W-1];
            mag = neg ? V_W'(-v) : V_W'(v);
            rm  = (mag + V_W'(128)) >> 8;
            r   = neg ? -$signed(rm[R_W-1:0]) : $signed(rm[R_W-1:0]);
            e_full = v - (V_W'(r) <<< 8);
            e   = r_item_reg.interior ? e_full[E_W-1:0] : '0;
            if (r < 0)
                out_lvl_next[c] = '0;
            else if (r > R_W'(255))
                out_lvl_next[c] = 8'hFF;
            else
                out_lvl_next[c] = r[OUT_W-1:0];
            a_data[c]  = lp0_reg[c] + share(e, 5'sd3);
            b_data[c]  = lp1_reg[c] + share(e, 5'sd5);
            lp1_next[c] = share(e, 5'sd1);
            rc_next[c]  = share(e, 5'sd7);
        end
        lp0_next = b_data;
        if (r_item_reg.last_col)
        begin
            lp0_next = '0;
            lp1_next = '0;
            rc_next  = '0;
        end
    end

    // write port: clearing pass, left write, last-column write, deferred write
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = def_addr_reg;
        wr_data = def_data_reg;
        def_valid_next = def_valid_reg;
        def_addr_next  = def_addr_reg;
        def_data_next  = def_data_reg;
        priority if (!clear_done)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg[ADDR_W-1:0];
            wr_data = '0;
        end
        else if (fire_r && r_item_reg.has_left)
        begin
            wr_en   = 1'b1;
            wr_addr = r_item_reg.col - ADDR_W'(1);
            wr_data = a_data;
            if (r_item_reg.last_col)
            begin
                def_valid_next = 1'b1;
                def_addr_next  = r_item_reg.col;
                def_data_next  = b_data;
            end
        end
        else if (fire_r && r_item_reg.last_col)
        begin
            wr_en   = 1'b1;
            wr_addr = r_item_reg.col;
            wr_data = b_data;
        end
        else if (def_valid_reg)
        begin
            wr_en = 1'b1;
            def_valid_next = 1'b0;
        end
    end

    // bypass of writes not yet visible at the read
    always_comb
    begin
        fwd_hit_next  = 1'b1;
        fwd_data_next = wr_data;
        priority if (wr_en && wr_addr == head_item.col)
            fwd_data_next = wr_data;
        else if (def_valid_next && !def_valid_reg && def_addr_next == head_item.col)
            fwd_data_next = def_data_next;
        else if (def_valid_reg && def_addr_reg == head_item.col)
            fwd_data_next = def_data_reg;
        else
            fwd_hit_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_q_reg     <= line_mem[head_item.col];
            fwd_hit_reg  <= fwd_hit_next;
            fwd_data_reg <= fwd_data_next;
            r_item_reg   <= head_item;
        end
        if (fire_r)
        begin
            out_lvl_reg <= out_lvl_next;
            out_end_reg <= r_item_reg.frame_end;
        end
        def_addr_reg <= def_addr_next;
        def_data_reg <= def_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            def_valid_reg <= 1'b0;
            rc_reg        <= '0;
            lp0_reg       <= '0;
            lp1_reg       <= '0;
        end
        else
        begin
            if (!clear_done)
                clr_cnt_reg <= clr_cnt_reg + (ADDR_W+1)'(1);
            if (adv)
            begin
                r_valid_reg   <= rd_en;
                out_valid_reg <= r_valid_reg;
            end
            def_valid_reg <= def_valid_next;
            if (fire_r)
            begin
                rc_reg  <= rc_next;
                lp0_reg <= lp0_next;
                lp1_reg <= lp1_next;
            end
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.red_out   = out_lvl_reg[0];
    assign res.green_out = out_lvl_reg[1];
    assign res.blue_out  = out_lvl_reg[2];
    assign res.frame_end = out_end_reg;
endmodule
`default_nettype wire

// File: rtl/floyd_steinberg_dither.sv
// Floyd-Steinberg error-diffusion dither, top level.
// Depends on fsd_pkg, fsd_pix_if, fsd_res_if, fsd_front, fsd_queue, fsd_back.
//
// Takes one RGB pixel per transaction in raster order (8.4 fixed point per
// channel) and returns one dithered 8-bit RGB result per pixel, in order, with
// frame_end on the last pixel of the frame. Throughput is one pixel per clock
// while the receiver keeps res.ready high; the path from input transaction to
// result valid runs through the queue write, the line store read and the result
// register. After reset the block sweeps its 4096-entry line error store to
// zero with pix.ready held low; register writes are taken during that time.
// Registers: index 0 image_width, 1 image_height, 2 dither_enable; write them
// only while the block is idle.
`default_nettype none
module floyd_steinberg_dither
    import fsd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    fsd_pix_if.sink               pix,
    fsd_res_if.source             res,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);
    cfg_t  cfg_reg;
    logic  clear_done;
    logic  push_valid, push_ready, head_valid, pop;
    item_t push_item, head_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= WIDTH_RST;
            cfg_reg.height <= HEIGHT_RST;
            cfg_reg.dither <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  cfg_reg.width  <= cfg_data[WID_W-1:0];
                REG_HEIGHT: cfg_reg.height <= cfg_data[HGT_W-1:0];
                REG_DITHER: cfg_reg.dither <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // front: position tracking and edge classification
    fsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .cfg        (cfg_reg),
        .clear_done (clear_done),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    // short queue decouples the two halves
    fsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // back: error store, quantizer, diffusion, result register
    fsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .clear_done (clear_done),
        .res        (res)
    );
endmodule
`default_nettype wire

// File: rtl/fsd_checker.sv
// Port-level checks of the dither block, bound to the top level.
// Depends on floyd_steinberg_dither's ports only.
`default_nettype none
module fsd_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic pix_valid,
    input wire logic pix_ready,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire logic [7:0] red_out,
    input wire logic frame_end
);
    logic [2:0] outstanding_reg;
    logic       in_take, out_take;

    assign in_take  = pix_valid && pix_ready;
    assign out_take = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else
            outstanding_reg <= outstanding_reg + 3'(in_take) - 3'(out_take);
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(red_out) && $stable(frame_end))
        else $error("result payload changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> outstanding_reg != 3'd0)
        else $error("result without an accepted pixel");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 3'd4)
        else $error("more pixels in flight than the pipeline holds");
endmodule

bind floyd_steinberg_dither fsd_checker u_fsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix.valid),
    .pix_ready (pix.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .red_out   (res.red_out),
    .frame_end (res.frame_end)
);
`default_nettype wire

// File: tb/fsd_dither_checker.sv
// Scoreboard for the error-diffusion dither: watches both channels, predicts
// each result from the pixel stream and the register writes. Uses fsd_pkg.
`timescale 1ns / 1ps
module fsd_dither_checker
    import fsd_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    fsd_pix_if                   pix,
    fsd_res_if                   res,
    input wire logic             cfg_we,
    input wire logic [IDX_W-1:0] cfg_index,
    input wire logic [CFG_W-1:0] cfg_data,
    output int                   fail_count,
    output int                   pending
);
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fend;
    } dither_res_t;

    dither_res_t expected_q[$];

    int        line_err[MAX_WIDTH][3];
    int        carry_r[3];
    int        low_pend[2][3];
    int        col_pos;
    int        row_pos;
    int        width_reg;
    int        height_reg;
    bit        dither_reg;

    assign pending = expected_q.size();

    function automatic int share_floor(int e, int k);
        int p;
        p = e * k;
        if (p >= 0)
            return p / 16;
        return -((-p + 15) / 16);
    endfunction

    task automatic predict_pixel(input logic [11:0] r_in, input logic [11:0] g_in,
                                 input logic [11:0] b_in);
        int w, h, x, v, r, e, lvl, c;
        bit lastc, lastr, inner;
        int chan_in[3];
        logic [7:0] lv[3];
        dither_res_t t;
        chan_in[0] = r_in;
        chan_in[1] = g_in;
        chan_in[2] = b_in;
        w = (width_reg == 0) ? 1 : width_reg;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        h = (height_reg == 0) ? 1 : height_reg;
        x = (col_pos >= w) ? w - 1 : col_pos;
        lastc = (x + 1 >= w);
        lastr = (row_pos + 1 >= h);
        inner = dither_reg && x != 0 && !lastc && !lastr;
        for (c = 0; c < 3; c++)
        begin
            v = chan_in[c] * 16 + line_err[x][c] + carry_r[c];
            if (v >= 0)
                r = (v + 128) / 256;
            else
                r = -((-v + 128) / 256);
            e = inner ? v - r * 256 : 0;
            lvl = r < 0 ? 0 : (r > 255 ? 255 : r);
            lv[c] = lvl[7:0];
            low_pend[0][c] += share_floor(e, 3);
            if (x >= 1)
                line_err[x-1][c] = low_pend[0][c];
            low_pend[0][c] = low_pend[1][c] + share_floor(e, 5);
            low_pend[1][c] = share_floor(e, 1);
            carry_r[c] = share_floor(e, 7);
            if (lastc)
            begin
                line_err[x][c] = low_pend[0][c];
                low_pend[0][c] = 0;
                low_pend[1][c] = 0;
                carry_r[c] = 0;
            end
        end
        t.red = lv[0];
        t.green = lv[1];
        t.blue = lv[2];
        t.fend = lastc && lastr;
        expected_q.insert(expected_q.size(), t);
        if (lastc)
        begin
            col_pos = 0;
            row_pos = lastr ? 0 : row_pos + 1;
        end
        else
            col_pos = x + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dither_res_t t;
        if (!rst_n)
        begin
            foreach (line_err[i, j])
                line_err[i][j] = 0;
            foreach (carry_r[i])
                carry_r[i] = 0;
            foreach (low_pend[i, j])
                low_pend[i][j] = 0;
            col_pos = 0;
            row_pos = 0;
            width_reg = WIDTH_RST;
            height_reg = HEIGHT_RST;
            dither_reg = 1'b1;
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WIDTH:  width_reg = cfg_data[WID_W-1:0];
                    REG_HEIGHT: height_reg = cfg_data[HGT_W-1:0];
                    REG_DITHER: dither_reg = cfg_data[0];
                    default: ;
                endcase
            end
            // the result side is checked first; latency keeps this order safe
            if (res.valid && res.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result transaction");
                    fail_count++;
                end
                else
                begin
                    t = expected_q.pop_front();
                    if (res.red_out !== t.red)
                    begin
                        $error("red_out exp %0d got %0d", t.red, res.red_out);
                        fail_count++;
                    end
                    if (res.green_out !== t.green)
                    begin
                        $error("green_out exp %0d got %0d", t.green, res.green_out);
                        fail_count++;
                    end
                    if (res.blue_out !== t.blue)
                    begin
                        $error("blue_out exp %0d got %0d", t.blue, res.blue_out);
                        fail_count++;
                    end
                    if (res.frame_end !== t.fend)
                    begin
                        $error("frame_end exp %0d got %0d", t.fend, res.frame_end);
                        fail_count++;
                    end
                end
            end
            if (pix.valid && pix.ready)
                predict_pixel(pix.red_in, pix.green_in, pix.blue_in);
        end
    end
endmodule

// File: tb/tb_top.sv
// Top of the dither testbench: clock, reset, pixel stimulus, register phases
// and verdict. Depends on fsd_pkg, the channel interfaces and the checker.
`timescale 1ns / 1ps
module tb_top;
    import fsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;  // covers the line error store sweep

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    int               idle_cycles;
    int               send_idle_pct;
    int               recv_stall_pct;

    fsd_pix_if pix();
    fsd_res_if res();

    floyd_steinberg_dither DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fsd_dither_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: ready redrawn each cycle against the current stall rate.
    always @(posedge clk)
        res.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: counts cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("floyd_steinberg_dither: mismatch");
            $finish;
        end
    end

    // One pixel transaction; random gaps before it per the sender idle rate.
    task automatic send_pixel(input logic [11:0] r, input logic [11:0] g,
                              input logic [11:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid    <= 1'b1;
        pix.red_in   <= r;
        pix.green_in <= g;
        pix.blue_in  <= b;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
    endtask

    task automatic send_random(input int n);
        int k;
        logic [11:0] base;
        for (k = 0; k < n; k++)
        begin
            // mostly random levels, sometimes near the rails to drive saturation
            case ($urandom_range(3))
                0: send_pixel(12'($urandom), 12'($urandom), 12'($urandom));
                1: send_pixel(12'($urandom_range(8)), 12'hFFF - 12'($urandom_range(8)),
                              12'($urandom));
                default:
                begin
                    base = 12'($urandom);
                    send_pixel(base, base ^ 12'h008, base + 12'($urandom_range(15)));
                end
            endcase
        end
    endtask

    // Registers change only with the block drained.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
        pix.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_size(input int w, input int h, input bit dith);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_DITHER, dith);
    endtask

    initial
    begin
        int ph;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        pix.valid      = 1'b0;
        pix.red_in     = '0;
        pix.green_in   = '0;
        pix.blue_in    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: small frame, rails, the round-half cases (x.8 up/down),
        // saturation from diffused error, and the all-ones bit pattern.
        set_size(4, 3, 1'b1);
        send_pixel(12'h000, 12'hFFF, 12'h008);
        send_pixel(12'hFFF, 12'h000, 12'h007);
        send_pixel(12'h008, 12'hFF8, 12'hAAA);
        send_pixel(12'h555, 12'hFF7, 12'h018);
        send_pixel(12'hFF9, 12'h007, 12'hFFF);
        send_pixel(12'h00F, 12'hFF0, 12'h888);
        send_pixel(12'hFFC, 12'h003, 12'h777);
        send_pixel(12'h123, 12'hFED, 12'h0F8);
        repeat (4) send_pixel(12'hFFF, 12'h000, 12'h008);
        // Zero sizes act as one; one-pixel frames; dither off still rounds.
        set_size(0, 0, 1'b0);
        send_pixel(12'h008, 12'hFF8, 12'h7F7);
        send_pixel(12'hFFF, 12'h000, 12'h555);
        // Oversized width saturates to the store depth; narrow height.
        set_size(8191, 2, 1'b1);
        repeat (3) send_pixel(12'($urandom), 12'($urandom), 12'($urandom));
        // Shrink mid-frame: column beyond the new width counts as last.
        set_size(2, 3, 1'b1);
        repeat (5) send_pixel(12'($urandom), 12'($urandom), 12'($urandom));

        // Random phases: no idling, sender idle, receiver stalls, both.
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 46;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 46;
                end
                default:
                begin
                    send_idle_pct = 34;
                    recv_stall_pct = 34;
                end
            endcase
            case (ph)
                0: set_size(7, 6, 1'b1);
                1: set_size(1, 9, 1'b1);
                2: set_size(12, 1, 1'b1);
                3: set_size(3, 5, 1'b0);
                4: set_size(4096, 1, 1'b1);
                5: set_size(5, 16384, 1'b1);
                6: set_size($urandom_range(2, 16), $urandom_range(2, 8), 1'b1);
                default: set_size(9, 4, 1'b1);
            endcase
            send_random(ph == 4 ? 40 : 85);
        end

        pix.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("floyd_steinberg_dither: match");
        else
            $display("floyd_steinberg_dither: mismatch");
        $finish;
    end
endmodule

// File: files.f
rtl/fsd_pkg.sv
rtl/fsd_pix_if.sv
rtl/fsd_res_if.sv
rtl/fsd_front.sv
rtl/fsd_queue.sv
rtl/fsd_back.sv
rtl/floyd_steinberg_dither.sv
rtl/fsd_checker.sv
tb/fsd_dither_checker.sv
tb/tb_top.sv
